// ===== sv/nsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the NMEA sentence decoder.
// Used by nsd_parse_core, nmea_sentence_decoder_unit and nsd_checker; no dependencies.
package nsd_pkg;

  // Widths of the result fields, message ID registers and ports, and the number of ID slots.
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned ID_W       = 24;
  localparam int unsigned NUM_SLOTS  = 5;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_ADDR_W = 5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd2;

  // Character codes recognized by the parser.
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_VT     = 8'h0B;
  localparam logic [7:0] CHAR_FF     = 8'h0C;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_ID_SLOT0 = 3'd0;
  localparam logic [2:0] REG_ID_SLOT1 = 3'd1;
  localparam logic [2:0] REG_ID_SLOT2 = 3'd2;
  localparam logic [2:0] REG_ID_SLOT3 = 3'd3;
  localparam logic [2:0] REG_ID_SLOT4 = 3'd4;

  // Reset contents of the ID slots: "CHA", "ACC", "REV", "SHO", "RES".
  localparam logic [ID_W-1:0] ID_SLOT0_RST = 24'h434841;
  localparam logic [ID_W-1:0] ID_SLOT1_RST = 24'h414343;
  localparam logic [ID_W-1:0] ID_SLOT2_RST = 24'h524556;
  localparam logic [ID_W-1:0] ID_SLOT3_RST = 24'h53484F;
  localparam logic [ID_W-1:0] ID_SLOT4_RST = 24'h524553;

  typedef logic [ID_W-1:0] msg_id_t;
  typedef msg_id_t [NUM_SLOTS-1:0] slot_ids_t;

  // One decoded result per input byte.
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [SLOT_W-1:0]         slot;
    logic signed [FIELD_W-1:0] field_a;
    logic signed [FIELD_W-1:0] field_b;
    logic signed [FIELD_W-1:0] field_c;
  } result_t;

endpackage

// ===== sv/nsd_parse_core.sv =====
`timescale 1ns / 1ps
// Sentence parser state and per-byte next-state logic of the NMEA decoder.
// Depends on nsd_pkg; the result is combinational and registered by the top level.
module nsd_parse_core #(
  parameter int unsigned MAX_SENTENCE_LEN = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic [7:0]         byte_i,
  input  nsd_pkg::slot_ids_t slot_ids_i,
  output nsd_pkg::result_t   result_o
);

  localparam logic [7:0] MaxLenC = 8'(MAX_SENTENCE_LEN);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  typedef struct packed {
    logic done;
    logic neg;
    logic started;
  } field_flags_t;

  phase_e       phase_q, phase_d;
  logic [7:0]   pos_q, pos_d;
  logic [7:0]   xor_q, xor_d;
  logic [23:0]  id_q, id_d;
  logic [1:0]   hexcnt_q, hexcnt_d;
  logic [7:0]   rcv_q, rcv_d;
  logic [1:0]   fnum_q, fnum_d;
  field_flags_t flags_q, flags_d;
  logic signed [nsd_pkg::FIELD_W-1:0] field_q [3];
  logic signed [nsd_pkg::FIELD_W-1:0] field_d [3];

  // Character classes of the incoming byte.
  logic       is_digit, is_hex, is_blank;
  logic [3:0] hex_val;
  assign is_digit = (byte_i >= nsd_pkg::CHAR_ZERO) && (byte_i <= nsd_pkg::CHAR_NINE);
  assign is_hex   = is_digit ||
                    ((byte_i >= nsd_pkg::CHAR_UPPER_A) && (byte_i <= nsd_pkg::CHAR_UPPER_F));
  assign is_blank = (byte_i == nsd_pkg::CHAR_SPACE) || (byte_i == nsd_pkg::CHAR_TAB) ||
                    (byte_i == nsd_pkg::CHAR_VT) || (byte_i == nsd_pkg::CHAR_FF) ||
                    (byte_i == nsd_pkg::CHAR_CR);
  always_comb begin
    logic [7:0] diff;
    diff = is_digit ? (byte_i - nsd_pkg::CHAR_ZERO) : (byte_i - nsd_pkg::HEX_ALPHA_OFS);
    hex_val = diff[3:0];
  end

  // Decimal accumulate of the current field: v*10 +/- digit, saturated to 16 bits.
  logic signed [nsd_pkg::FIELD_W-1:0] fv_cur, fv_next;
  always_comb begin
    case (fnum_q)
      2'd0:    fv_cur = field_q[0];
      2'd1:    fv_cur = field_q[1];
      2'd2:    fv_cur = field_q[2];
      default: fv_cur = '0;
    endcase
  end

  always_comb begin
    logic signed [20:0] vx;
    logic signed [20:0] prod;
    logic signed [20:0] dig;
    logic signed [20:0] sum;
    vx   = 21'(fv_cur);
    prod = (vx <<< 3) + (vx <<< 1);
    dig  = $signed({17'd0, byte_i[3:0]});
    if (flags_q.neg) begin
      sum = prod - dig;
      if (sum < -21'sd32768) begin
        fv_next = 16'sh8000;
      end else begin
        fv_next = sum[15:0];
      end
    end else begin
      sum = prod + dig;
      if (sum > 21'sd32767) begin
        fv_next = 16'sh7FFF;
      end else begin
        fv_next = sum[15:0];
      end
    end
  end

  // Lowest matching ID slot wins.
  logic                       slot_hit;
  logic [nsd_pkg::SLOT_W-1:0] slot_idx;
  always_comb begin
    slot_hit = 1'b0;
    slot_idx = '0;
    for (int s = nsd_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
      if (slot_ids_i[s] == id_q) begin
        slot_hit = 1'b1;
        slot_idx = nsd_pkg::SLOT_W'(s);
      end
    end
  end

  // Next-state and result for the byte at the input.
  always_comb begin
    logic fail;
    logic clear;
    logic start;
    fail  = 1'b0;
    clear = 1'b0;
    start = 1'b0;
    phase_d  = phase_q;
    pos_d    = pos_q;
    xor_d    = xor_q;
    id_d     = id_q;
    hexcnt_d = hexcnt_q;
    rcv_d    = rcv_q;
    fnum_d   = fnum_q;
    flags_d  = flags_q;
    field_d  = field_q;
    result_o = '0;

    case (phase_q)
      PH_PAYLOAD: begin
        if ((pos_q >= MaxLenC) || (byte_i == nsd_pkg::CHAR_DOLLAR) ||
            (byte_i == nsd_pkg::CHAR_NL)) begin
          fail = 1'b1;
        end else if (byte_i == nsd_pkg::CHAR_STAR) begin
          pos_d    = pos_q + 8'd1;
          hexcnt_d = '0;
          rcv_d    = '0;
          phase_d  = PH_CHECK;
        end else begin
          pos_d = pos_q + 8'd1;
          if (pos_q <= 8'd3) begin
            id_d  = {id_q[15:0], byte_i};
            xor_d = xor_q ^ byte_i;
          end else if (pos_q == 8'd4) begin
            // The byte after the ID always counts as a field separator.
            xor_d   = xor_q ^ nsd_pkg::CHAR_COMMA;
            fnum_d  = '0;
            flags_d = '0;
          end else begin
            xor_d = xor_q ^ byte_i;
            if (byte_i == nsd_pkg::CHAR_COMMA) begin
              if (fnum_q != 2'd3) begin
                fnum_d = fnum_q + 2'd1;
              end
              flags_d = '0;
            end else if ((fnum_q != 2'd3) && !flags_q.done) begin
              if (!flags_q.started && is_blank) begin
                flags_d = flags_q;
              end else if (!flags_q.started && (byte_i == nsd_pkg::CHAR_PLUS)) begin
                flags_d.started = 1'b1;
              end else if (!flags_q.started && (byte_i == nsd_pkg::CHAR_MINUS)) begin
                flags_d.started = 1'b1;
                flags_d.neg     = 1'b1;
              end else begin
                flags_d.started = 1'b1;
                if (!is_digit) begin
                  flags_d.done = 1'b1;
                end else begin
                  field_d[fnum_q] = fv_next;
                end
              end
            end
          end
        end
      end
      PH_CHECK: begin
        if (is_hex) begin
          if (hexcnt_q >= 2'd2) begin
            fail = 1'b1;
          end else begin
            rcv_d    = {rcv_q[3:0], hex_val};
            hexcnt_d = hexcnt_q + 2'd1;
          end
        end else if (byte_i == nsd_pkg::CHAR_NL) begin
          if ((hexcnt_q != 2'd2) || (pos_q < 8'd5) || (rcv_q != xor_q) || !slot_hit) begin
            fail = 1'b1;
          end else begin
            result_o.status  = nsd_pkg::STATUS_DONE;
            result_o.slot    = slot_idx;
            result_o.field_a = field_q[0];
            result_o.field_b = (slot_idx >= 3'd3) ? field_q[1] : '0;
            result_o.field_c = (slot_idx >= 3'd4) ? field_q[2] : '0;
            phase_d = PH_WAIT;
            clear   = 1'b1;
          end
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        phase_d = PH_WAIT;
        if (byte_i == nsd_pkg::CHAR_DOLLAR) begin
          clear   = 1'b1;
          start   = 1'b1;
          phase_d = PH_PAYLOAD;
        end
      end
    endcase

    if (fail) begin
      result_o = '0;
      result_o.status = nsd_pkg::STATUS_ERROR;
      phase_d = PH_WAIT;
      clear   = 1'b1;
    end

    // Sentence state clears after every error, completion and start; a start sets the position to 1.
    if (clear) begin
      pos_d    = start ? 8'd1 : 8'd0;
      xor_d    = '0;
      id_d     = '0;
      hexcnt_d = '0;
      rcv_d    = '0;
      fnum_d   = '0;
      flags_d  = '0;
      field_d[0] = '0;
      field_d[1] = '0;
      field_d[2] = '0;
    end
  end

  // State registers advance once per accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      pos_q    <= '0;
      xor_q    <= '0;
      id_q     <= '0;
      hexcnt_q <= '0;
      rcv_q    <= '0;
      fnum_q   <= '0;
      flags_q  <= '0;
      field_q[0] <= '0;
      field_q[1] <= '0;
      field_q[2] <= '0;
    end else if (byte_valid_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      xor_q    <= xor_d;
      id_q     <= id_d;
      hexcnt_q <= hexcnt_d;
      rcv_q    <= rcv_d;
      fnum_q   <= fnum_d;
      flags_q  <= flags_d;
      field_q[0] <= field_d[0];
      field_q[1] <= field_d[1];
      field_q[2] <= field_d[2];
    end
  end

endmodule

// ===== sv/nmea_sentence_decoder_unit.sv =====
`timescale 1ns / 1ps
// Top level of the NMEA sentence decoder: configuration registers, parser and output register.
// Depends on nsd_pkg and nsd_parse_core.
//
//  Channel   Direction  Content
//  s_axis    in         tdata[7:0] byte_in
//  m_axis    out        tuser[1:0] status; tdata slot, field_a, field_b, field_c
//  APB       in/out     five 24-bit message ID slots at byte addresses 0x00..0x10
//
// Every byte yields exactly one result transaction, in the cycle after it is accepted.
// Sustained rate is one byte per cycle while m_axis is not stalled; the parser state and
// the output register both update in the cycle of acceptance.
// s_axis_tready drops only while a result waits in the output register and m_axis is stalled.
// Reset returns the parser to waiting for '$' and loads the default message IDs.
module nmea_sentence_decoder_unit #(
  parameter int unsigned MAX_SENTENCE_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [nsd_pkg::OUT_DATA_W-1:0] m_axis_tdata, // [2:0] message_slot, [18:3] field_a,
                                                       // [34:19] field_b, [50:35] field_c
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [nsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  nsd_pkg::slot_ids_t slot_ids_q;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_ids_q[0] <= nsd_pkg::ID_SLOT0_RST;
      slot_ids_q[1] <= nsd_pkg::ID_SLOT1_RST;
      slot_ids_q[2] <= nsd_pkg::ID_SLOT2_RST;
      slot_ids_q[3] <= nsd_pkg::ID_SLOT3_RST;
      slot_ids_q[4] <= nsd_pkg::ID_SLOT4_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        nsd_pkg::REG_ID_SLOT0: slot_ids_q[0] <= pwdata[23:0];
        nsd_pkg::REG_ID_SLOT1: slot_ids_q[1] <= pwdata[23:0];
        nsd_pkg::REG_ID_SLOT2: slot_ids_q[2] <= pwdata[23:0];
        nsd_pkg::REG_ID_SLOT3: slot_ids_q[3] <= pwdata[23:0];
        nsd_pkg::REG_ID_SLOT4: slot_ids_q[4] <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      nsd_pkg::REG_ID_SLOT0: prdata = {8'd0, slot_ids_q[0]};
      nsd_pkg::REG_ID_SLOT1: prdata = {8'd0, slot_ids_q[1]};
      nsd_pkg::REG_ID_SLOT2: prdata = {8'd0, slot_ids_q[2]};
      nsd_pkg::REG_ID_SLOT3: prdata = {8'd0, slot_ids_q[3]};
      nsd_pkg::REG_ID_SLOT4: prdata = {8'd0, slot_ids_q[4]};
      default:               prdata = '0;
    endcase
  end

  // Parser: state advances on each accepted input transaction.
  logic             in_accept;
  nsd_pkg::result_t result;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  nsd_parse_core #(
    .MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)
  ) u_parse_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_accept),
    .byte_i       (s_axis_tdata),
    .slot_ids_i   (slot_ids_q),
    .result_o     (result)
  );

  // Output register: loads on input acceptance, empties when taken.
  logic             out_valid_q;
  nsd_pkg::result_t out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tdata  = {5'd0, out_res_q.field_c, out_res_q.field_b,
                          out_res_q.field_a, out_res_q.slot};

endmodule

// ===== sv/nsd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the NMEA sentence decoder, attached to the top level by bind.
// Depends on nsd_pkg and nmea_sentence_decoder_unit.
module nsd_assertions (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [nsd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  // Every accepted byte produces a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte produced no result");

  // Only a completed sentence carries slot and field data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != nsd_pkg::STATUS_DONE) |-> (m_axis_tdata == '0))
    else $error("nonzero payload on a result that is not a completed sentence");

  // A completed sentence names one of the five slots, with padding bits clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == nsd_pkg::STATUS_DONE) |->
      (m_axis_tdata[2:0] <= 3'd4) && (m_axis_tdata[55:51] == 5'd0))
    else $error("completed sentence with invalid slot or padding");

  // While the output is free the input is never back-pressured.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

endmodule

bind nmea_sentence_decoder_unit nsd_assertions u_nsd_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
